// ===== sv/ipv4_address_set_with_aging_unit_assert.svh =====
// assertion macros for the ipv4 address set checker
// needs clk and rst in scope where used
`ifndef IPV4_ADDRESS_SET_WITH_AGING_UNIT_ASSERT_SVH
`define IPV4_ADDRESS_SET_WITH_AGING_UNIT_ASSERT_SVH

// same-cycle implication
`define IPV4AS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPV4AS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ipv4as_pkg.sv =====
// shared types and constants for the ipv4 address set with aging
// used by the cell, the top level and the checker
package ipv4as_pkg;

  localparam int ENTRIES_DEFAULT = 256;
  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;
  localparam int TMO_W = 16;
  localparam int CNT_W = 9;
  localparam int KIND_W = 3;
  localparam int STATUS_W = 3;

  localparam logic [KIND_W-1:0] KIND_TEST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TICK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SWEEP = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXISTS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd4;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX = 1'b1;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd0;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 9'd256;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 9'd256;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_COMPARE,
    CELL_WRITE_HIT,
    CELL_WRITE_FREE,
    CELL_CLEAR_HIT,
    CELL_SWEEP,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic aging;
    logic [ADDR_W-1:0] key;
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] expiry;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic live;
    logic free;
    logic drop;
  } chain_t;

endpackage

// ===== sv/ipv4as_cell.sv =====
// one slot of the address table: key, expiry and per-request flags
// depends on ipv4as_pkg; chained to its neighbors by the top level
module ipv4as_cell
  import ipv4as_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  chain_t    chain_in,
  output chain_t    chain_out
);

  logic [ADDR_W-1:0] key;
  logic [TIME_W-1:0] expiry;
  logic hit_r;
  logic live_r;
  logic stale_r;
  logic drop;

  logic occupied;
  logic [TIME_W-1:0] ahead;
  logic [TIME_W-1:0] behind;
  logic claim;

  assign occupied = (expiry != '0);
  assign ahead = cmd.cur_time - expiry;
  assign behind = expiry - cmd.cur_time;
  assign claim = !occupied && !chain_in.free;

  assign chain_out.hit = chain_in.hit | hit_r;
  assign chain_out.live = chain_in.live | (hit_r & live_r);
  assign chain_out.free = chain_in.free | !occupied;
  assign chain_out.drop = drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= '0;
      hit_r <= 1'b0;
      live_r <= 1'b0;
      stale_r <= 1'b0;
      drop <= 1'b0;
    end else begin
      unique case (cmd.op)
        CELL_HOLD: begin
        end
        CELL_COMPARE: begin
          hit_r <= occupied && (key == cmd.key);
          live_r <= occupied && (!cmd.aging || ahead[TIME_W-1]);
          stale_r <= occupied && behind[TIME_W-1];
        end
        CELL_WRITE_HIT: begin
          if (hit_r) expiry <= cmd.expiry;
        end
        CELL_WRITE_FREE: begin
          if (claim) expiry <= cmd.expiry;
        end
        CELL_CLEAR_HIT: begin
          if (hit_r) expiry <= '0;
        end
        CELL_SWEEP: begin
          if (stale_r) expiry <= '0;
          drop <= stale_r;
        end
        CELL_SHIFT: begin
          drop <= chain_in.drop;
        end
        default: begin
        end
      endcase
    end
  end

  // key storage has no reset
  always_ff @(posedge clk) begin
    if ((cmd.op == CELL_WRITE_HIT && hit_r) || (cmd.op == CELL_WRITE_FREE && claim)) begin
      key <= cmd.key;
    end
  end

endmodule

// ===== sv/ipv4_address_set_with_aging_unit.sv =====
// test, add, delete and tick: compare state, then execute state, then registered done; no new request until idle
// sweep with aging on: busy while the drop flags shift one cell
// per cycle down the cell chain into the occupancy counter
// results cannot be stalled; done is high for one cycle per request
// synchronous reset clears all slots, time, count and config, with no clearing pass
// depends on ipv4as_pkg and ipv4as_cell
module ipv4_address_set_with_aging_unit
  import ipv4as_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [KIND_W-1:0]   kind,
  input  logic [ADDR_W-1:0]   address,
  input  logic [TMO_W-1:0]    add_timeout,
  output logic                busy,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic                member,
  output logic [ADDR_W-1:0]   echoed_address,
  output logic [CNT_W-1:0]    occupied_count,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int DRAIN_W = $clog2(ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_EXEC  = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [KIND_W-1:0] req_kind;
  logic [ADDR_W-1:0] req_addr;
  logic [TMO_W-1:0] req_tmo;
  logic [TIME_W-1:0] cur_time, cur_time_next;
  logic [CNT_W-1:0] count, count_next;
  logic [TMO_W-1:0] default_timeout;
  logic [CNT_W-1:0] max_entries;
  logic [DRAIN_W-1:0] drain_cnt, drain_cnt_next;

  logic emit;
  logic [STATUS_W-1:0] status_next;
  logic member_next;
  logic aging;
  logic zero_addr;
  logic [TMO_W-1:0] lifetime;
  logic [TIME_W-1:0] sum;
  logic [TIME_W-1:0] new_expiry;
  logic cfg_write;
  cell_op_t cell_op;
  cell_cmd_t cmd;
  chain_t chain [ENTRIES+1];
  chain_t tail;

  // config port
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_timeout <= TIMEOUT_RST;
      max_entries <= MAX_ENTRIES_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_TIMEOUT: default_timeout <= pwdata[TMO_W-1:0];
        REG_MAX: max_entries <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIMEOUT: prdata = {{(32-TMO_W){1'b0}}, default_timeout};
      REG_MAX: prdata = {{(32-CNT_W){1'b0}}, max_entries};
      default: prdata = '0;
    endcase
  end

  // expiry for an add
  assign aging = (default_timeout != '0);
  assign lifetime = (req_tmo != '0) ? req_tmo : default_timeout;
  assign sum = cur_time + {{(TIME_W-TMO_W){1'b0}}, lifetime};
  assign new_expiry = (!aging || sum == '0) ? TIME_W'(1) : sum;
  assign zero_addr = (req_addr == '0) &&
                     (req_kind == KIND_TEST || req_kind == KIND_ADD || req_kind == KIND_DELETE);

  assign cmd.op = cell_op;
  assign cmd.aging = aging;
  assign cmd.key = req_addr;
  assign cmd.cur_time = cur_time;
  assign cmd.expiry = new_expiry;

  // cell chain
  assign chain[0] = '0;
  assign tail = chain[ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ipv4as_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    cur_time_next = cur_time;
    count_next = count;
    drain_cnt_next = drain_cnt;
    cell_op = CELL_HOLD;
    emit = 1'b0;
    status_next = ST_OK;
    member_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CMP;
      end
      S_CMP: begin
        cell_op = CELL_COMPARE;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        emit = 1'b1;
        state_next = S_IDLE;
        if (zero_addr) begin
          status_next = ST_ZERO;
        end else begin
          unique case (req_kind)
            KIND_TEST: member_next = tail.live;
            KIND_ADD: begin
              if (count >= max_entries) begin
                status_next = ST_FULL;
              end else if (tail.hit) begin
                cell_op = CELL_WRITE_HIT;
                status_next = tail.live ? ST_EXISTS : ST_OK;
              end else if (tail.free) begin
                cell_op = CELL_WRITE_FREE;
                count_next = count + CNT_W'(1);
              end else begin
                status_next = ST_FULL;
              end
            end
            KIND_DELETE: begin
              if (tail.hit) begin
                cell_op = CELL_CLEAR_HIT;
                if (count != '0) count_next = count - CNT_W'(1);
              end else begin
                status_next = ST_ABSENT;
              end
            end
            KIND_TICK: cur_time_next = cur_time + TIME_W'(1);
            KIND_SWEEP: begin
              if (aging) begin
                cell_op = CELL_SWEEP;
                emit = 1'b0;
                drain_cnt_next = '0;
                state_next = S_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRAIN: begin
        cell_op = CELL_SHIFT;
        if (tail.drop && count != '0) count_next = count - CNT_W'(1);
        if (drain_cnt == DRAIN_W'(ENTRIES-1)) begin
          emit = 1'b1;
          state_next = S_IDLE;
        end else begin
          drain_cnt_next = drain_cnt + DRAIN_W'(1);
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_time <= '0;
      count <= '0;
      drain_cnt <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cur_time <= cur_time_next;
      count <= count_next;
      drain_cnt <= drain_cnt_next;
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_kind <= kind;
      req_addr <= address;
      req_tmo <= add_timeout;
    end
    if (emit) begin
      status <= status_next;
      member <= member_next;
      echoed_address <= req_addr;
      occupied_count <= count_next;
    end
  end

endmodule

// ===== sv/ipv4as_checker.sv =====
// port-level checker for the ipv4 address set, bound to the top level
// depends on ipv4as_pkg and the assertion macro header
`include "ipv4_address_set_with_aging_unit_assert.svh"

module ipv4as_checker
  import ipv4as_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [CNT_W-1:0]    occupied_count
);

  `IPV4AS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `IPV4AS_ASSERT_NEXT(a_accept_no_done, start && !busy, !done, "result right after accept")
  `IPV4AS_ASSERT_NOW(a_done_idle, done, !busy && $past(busy), "result strobe without prior work")
  `IPV4AS_ASSERT_NOW(a_count_limit, done, occupied_count <= COUNT_LIMIT, "count above limit")

endmodule

bind ipv4_address_set_with_aging_unit ipv4as_checker u_ipv4as_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .occupied_count (occupied_count)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// testbench for ipv4_address_set_with_aging_unit: directed and random request streams,
// each result checked field by field against an in-bench model of the address table
// depends on ipv4as_pkg and the unit's rtl
module tb
  import ipv4as_pkg::*;
();

  localparam int SLOTS = ENTRIES_DEFAULT;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQUESTS = 200;
  localparam int POOL_SIZE = 12;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT = 10;
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST = 3'd7;
  localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
  localparam logic [2:0] ADDR_MAX = {REG_MAX, 2'b00};
  localparam logic [ADDR_W-1:0] NO_ADDRESS = '0;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;
  localparam logic [TMO_W-1:0] USE_DEFAULT = '0;
  localparam logic [TMO_W-1:0] LONGEST = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                member;
    logic [ADDR_W-1:0]   addr;
    logic [CNT_W-1:0]    count;
  } response_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [KIND_W-1:0]   kind = KIND_TEST;
  logic [ADDR_W-1:0]   address = '0;
  logic [TMO_W-1:0]    add_timeout = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic                member;
  logic [ADDR_W-1:0]   echoed_address;
  logic [CNT_W-1:0]    occupied_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // model of the address table
  logic [ADDR_W-1:0] table_key [SLOTS];
  logic [TIME_W-1:0] table_expiry [SLOTS];
  logic [TIME_W-1:0] tick_count = '0;
  logic [CNT_W-1:0]  occupancy = '0;
  logic [CNT_W-1:0]  peak_occupancy = '0;
  logic [TMO_W-1:0]  lifetime_cfg = TIMEOUT_RST;
  logic [CNT_W-1:0]  capacity_cfg = MAX_ENTRIES_RST;

  response_t         expected_responses [$];
  logic [ADDR_W-1:0] address_pool [POOL_SIZE];
  logic              steady_stream = 1'b0;
  int                requests_sent = 0;
  int                sweeps_sent = 0;
  int                results_seen = 0;
  int                register_writes = 0;
  int                mismatches = 0;
  int                quiet_cycles = 0;

  ipv4_address_set_with_aging_unit #(
    .ENTRIES(SLOTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind(kind),
    .address(address),
    .add_timeout(add_timeout),
    .busy(busy),
    .done(done),
    .status(status),
    .member(member),
    .echoed_address(echoed_address),
    .occupied_count(occupied_count),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a lies after b, wrapping
  function automatic logic after_time(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = b - a;
    return diff[TIME_W-1];
  endfunction

  function automatic logic entry_live(logic [TIME_W-1:0] expiry);
    if (expiry == '0) return 1'b0;
    if (lifetime_cfg == '0) return 1'b1;
    return after_time(expiry, tick_count);
  endfunction

  function automatic int find_entry(logic [ADDR_W-1:0] a);
    int i;
    for (i = 0; i < SLOTS; i++) begin
      if (table_expiry[i] != '0 && table_key[i] == a) return i;
    end
    return SLOTS;
  endfunction

  function automatic response_t predict_response(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] a,
                                                 logic [TMO_W-1:0] t);
    response_t r;
    int s;
    int i;
    logic fresh;
    logic [TIME_W-1:0] expiry;
    r.status = ST_OK;
    r.member = 1'b0;
    r.addr = a;
    fresh = 1'b0;
    if ((k == KIND_TEST || k == KIND_ADD || k == KIND_DELETE) && a == NO_ADDRESS) begin
      r.status = ST_ZERO;
    end else begin
      case (k)
        KIND_TEST: begin
          s = find_entry(a);
          if (s < SLOTS && entry_live(table_expiry[s])) r.member = 1'b1;
        end
        KIND_ADD: begin
          if (occupancy >= capacity_cfg) begin
            r.status = ST_FULL;
          end else begin
            s = find_entry(a);
            if (s < SLOTS) begin
              if (entry_live(table_expiry[s])) r.status = ST_EXISTS;
            end else begin
              for (i = SLOTS - 1; i >= 0; i--) begin
                if (table_expiry[i] == '0) s = i;
              end
              if (s < SLOTS) fresh = 1'b1;
              else r.status = ST_FULL;
            end
            if (s < SLOTS) begin
              if (lifetime_cfg != '0) expiry = tick_count + ((t != '0) ? t : lifetime_cfg);
              else expiry = 1;
              if (expiry == '0) expiry = 1;
              table_key[s] = a;
              table_expiry[s] = expiry;
              if (fresh) occupancy++;
            end
          end
        end
        KIND_DELETE: begin
          s = find_entry(a);
          if (s < SLOTS) begin
            table_expiry[s] = '0;
            if (occupancy > 0) occupancy--;
          end else begin
            r.status = ST_ABSENT;
          end
        end
        KIND_TICK: begin
          tick_count++;
        end
        KIND_SWEEP: begin
          if (lifetime_cfg != '0) begin
            for (i = 0; i < SLOTS; i++) begin
              if (table_expiry[i] != '0 && after_time(tick_count, table_expiry[i])) begin
                table_expiry[i] = '0;
                if (occupancy > 0) occupancy--;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (occupancy > peak_occupancy) peak_occupancy = occupancy;
    r.count = occupancy;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (steady_stream) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                              input logic [TMO_W-1:0] t);
    int gap;
    start <= 1'b1;
    kind <= k;
    address <= a;
    add_timeout <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_responses.push_back(predict_response(k, a, t));
    requests_sent++;
    if (k == KIND_SWEEP) sweeps_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] where, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= where;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (where)
      ADDR_TIMEOUT: lifetime_cfg = value[TMO_W-1:0];
      ADDR_MAX: capacity_cfg = value[CNT_W-1:0];
      default: ;
    endcase
    register_writes++;
  endtask

  task automatic apply_settings(input int lifetime, input int capacity);
    wait_for_results();
    write_register(ADDR_TIMEOUT, lifetime);
    write_register(ADDR_MAX, capacity);
  endtask

  task automatic send_random_request();
    int roll;
    logic [KIND_W-1:0] k;
    logic [ADDR_W-1:0] a;
    logic [TMO_W-1:0] t;
    roll = $urandom_range(0, 99);
    if (roll < 30) k = KIND_TEST;
    else if (roll < 62) k = KIND_ADD;
    else if (roll < 78) k = KIND_DELETE;
    else if (roll < 92) k = KIND_TICK;
    else if (roll < 97) k = KIND_SWEEP;
    else k = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    roll = $urandom_range(0, 99);
    if (roll < 4) a = NO_ADDRESS;
    else if (roll < 85) a = address_pool[$urandom_range(0, POOL_SIZE - 1)];
    else a = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 40) t = USE_DEFAULT;
    else if (roll < 75) t = TMO_W'($urandom_range(1, 8));
    else if (roll < 92) t = TMO_W'($urandom);
    else t = LONGEST;
    send_request(k, a, t);
  endtask

  // zero address, extremes, duplicates, absent deletes and spare kinds with aging off
  task automatic test_request_basics();
    send_request(KIND_TEST, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_ADD, NO_ADDRESS, LONGEST);
    send_request(KIND_DELETE, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_ADD, ALL_ONES, LONGEST);
    send_request(KIND_ADD, 32'h0000_0001, USE_DEFAULT);
    send_request(KIND_ADD, 32'h8000_0000, 16'h0001);
    send_request(KIND_ADD, ALL_ONES, USE_DEFAULT);
    send_request(KIND_TEST, ALL_ONES, USE_DEFAULT);
    send_request(KIND_TEST, 32'h7FFF_FFFF, LONGEST);
    send_request(KIND_DELETE, 32'h0000_0001, USE_DEFAULT);
    send_request(KIND_DELETE, 32'h0000_0001, USE_DEFAULT);
    send_request(KIND_TEST, 32'h0000_0001, USE_DEFAULT);
    send_request(KIND_TICK, ALL_ONES, LONGEST);
    send_request(KIND_SWEEP, 32'h5555_AAAA, USE_DEFAULT);
    send_request(KIND_SPARE_FIRST, ALL_ONES, LONGEST);
    send_request(KIND_SPARE_FIRST + 3'd1, 32'hA5A5_5A5A, USE_DEFAULT);
    send_request(KIND_SPARE_LAST, 32'h0000_0001, LONGEST);
  endtask

  // expiry on the boundary, stale re-add, live re-add refresh, sweep keeps equal expiry
  task automatic test_aging_rules();
    apply_settings(3, SLOTS);
    send_request(KIND_ADD, 32'hC0A8_0001, USE_DEFAULT);
    send_request(KIND_ADD, 32'h0A00_0001, 16'h0001);
    send_request(KIND_TICK, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_TEST, 32'h0A00_0001, USE_DEFAULT);
    send_request(KIND_SWEEP, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_ADD, 32'h0A00_0001, 16'h0002);
    send_request(KIND_ADD, 32'hC0A8_0001, USE_DEFAULT);
    send_request(KIND_TICK, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_TICK, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_SWEEP, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_DELETE, 32'h0A00_0001, USE_DEFAULT);
  endtask

  // fill every slot, refuse further adds, lower the limit, then age the whole table out
  task automatic test_full_table();
    logic [ADDR_W-1:0] a;
    apply_settings(0, SLOTS);
    steady_stream = 1'b1;
    while (occupancy < SLOTS) begin
      a = $urandom;
      if (a == NO_ADDRESS) a = ALL_ONES;
      send_request(KIND_ADD, a, USE_DEFAULT);
    end
    steady_stream = 1'b0;
    send_request(KIND_ADD, ~table_key[0], USE_DEFAULT);
    send_request(KIND_ADD, table_key[$urandom_range(0, SLOTS - 1)], USE_DEFAULT);
    send_request(KIND_TEST, table_key[$urandom_range(0, SLOTS - 1)], USE_DEFAULT);
    send_request(KIND_SWEEP, NO_ADDRESS, USE_DEFAULT);
    apply_settings(0, 100);
    send_request(KIND_DELETE, table_key[$urandom_range(0, SLOTS - 1)], USE_DEFAULT);
    send_request(KIND_ADD, table_key[$urandom_range(0, SLOTS - 1)], USE_DEFAULT);
    apply_settings(2, SLOTS);
    repeat (3) send_request(KIND_TICK, NO_ADDRESS, USE_DEFAULT);
    send_request(KIND_SWEEP, NO_ADDRESS, USE_DEFAULT);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    int i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_settings(0, SLOTS);
        1: apply_settings(1, SLOTS);
        2: apply_settings(4, 8);
        3: apply_settings(65535, SLOTS);
        4: apply_settings(7, 0);
        5: apply_settings(3, 1);
        6: apply_settings($urandom_range(1, 20), $urandom_range(2, 16));
        default: apply_settings(0, 5);
      endcase
      for (i = 0; i < POOL_SIZE; i++) address_pool[i] = $urandom;
      steady_stream = (phase % 3 == 1);
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        // hold off until the unit has answered everything
        if (n == PHASE_REQUESTS / 2) wait_for_results();
        send_random_request();
      end
    end
    steady_stream = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 name, results_seen, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    response_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d with no request pending: address %h, status %0d",
                   results_seen, echoed_address, status);
      end else begin
        want = expected_responses.pop_front();
        check_field("status", want.status, status);
        check_field("member", want.member, member);
        check_field("echoed_address", want.addr, echoed_address);
        check_field("occupied_count", want.count, occupied_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < SLOTS; i++) begin
      table_key[i] = '0;
      table_expiry[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_request_basics();
    test_aging_rules();
    test_full_table();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_responses.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", expected_responses.size());
    end
    $display("covered %0d requests including %0d sweeps, %0d results checked",
             requests_sent, sweeps_sent, results_seen);
    $display("%0d register writes, occupancy peaked at %0d of %0d slots, %0d ticks elapsed",
             register_writes, peak_occupancy, SLOTS, tick_count);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
